// ===== rtl/rcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rcfp_pkg
// Shared types and constants for the RGB chain frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcfp_pkg;

    localparam int BYTE_W        = 8;
    localparam int MAX_FRAME_DEF = 64;

    localparam logic [BYTE_W-1:0] FRAME_END   = 8'h0d;
    localparam logic [BYTE_W-1:0] HEADER_SKIP = 8'd3;
    localparam logic [BYTE_W-1:0] MIN_LEN     = 8'd4;

    typedef enum logic [1:0] {
        KIND_RED   = 2'd0,
        KIND_GREEN = 2'd1,
        KIND_BLUE  = 2'd2,
        KIND_TX    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } t_state;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/rcfp_rx_if.sv =====
// ----------------------------------------------------------------------------
// rcfp_rx_if
// Receive channel: one serial byte per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rcfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/rcfp_tx_if.sv =====
// ----------------------------------------------------------------------------
// rcfp_tx_if
// Result channel: duty updates and bytes to forward down the chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rcfp_tx_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/rcfp_fwd_mem.sv =====
// ----------------------------------------------------------------------------
// rcfp_fwd_mem
// Forward buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcfp_fwd_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_wr_en,
    input  wire logic [AW-1:0]             i_wr_addr,
    input  wire logic [rcfp_pkg::BYTE_W-1:0] i_wr_data,
    input  wire logic                      i_rd_en,
    input  wire logic [AW-1:0]             i_rd_addr,
    output      logic [rcfp_pkg::BYTE_W-1:0] o_rd_data
);
    import rcfp_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rcfp_out_reg.sv =====
// ----------------------------------------------------------------------------
// rcfp_out_reg
// Output register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcfp_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load_en,
    input  wire rcfp_pkg::t_result i_load,
    output      logic              o_free,
    rcfp_tx_if.source              o_tx
);
    import rcfp_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_free = !r_valid || o_tx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load_en) begin
            r_data <= i_load;
        end
    end

    assign o_tx.valid = r_valid;
    assign o_tx.kind  = r_data.kind;
    assign o_tx.value = r_data.value;
    assign o_tx.last  = r_data.last;

endmodule

`default_nettype wire

// ===== rtl/rgb_chain_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// rgb_chain_frame_parser_core
// Daisy-chain RGB frame receiver with duty outputs and frame forwarding.
// ----------------------------------------------------------------------------
// Usage:
//   i_rx carries received serial bytes, one per transaction. o_tx carries
//   results: red/green/blue duty updates (last=1) and the rebuilt frame to
//   forward (kind 3), whose final byte 0x0d has last=1.
//   Frame: length L, red, green, blue, payload, 0x0d as the L-th byte.
//   Payload is kept in a single-port-write, registered-read buffer of
//   MAX_FRAME bytes; a good terminator replays length-3, payload, 0x0d.
// Timing:
//   A duty result is registered and appears on o_tx the cycle after its
//   byte is taken. A replay of N = L-3 bytes issues a buffer read for each
//   buffered byte (ST_READ), then loads it into the output register
//   (ST_SEND); the terminator is loaded last, straight from ST_READ.
//   i_rx.ready is low during the replay.
// Reset:
//   Synchronous, active low. Clears the parser to wait for a length byte
//   and empties the output register. The buffer is not cleared; only
//   entries written by the current frame are ever replayed.
// Stall:
//   A result waits in the output register while o_tx.ready is low; input
//   is taken only when that register is free or draining in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_chain_frame_parser_core #(
    parameter int MAX_FRAME = rcfp_pkg::MAX_FRAME_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rcfp_rx_if.sink   i_rx,
    rcfp_tx_if.source o_tx
);
    import rcfp_pkg::*;

    localparam int AW = $clog2(MAX_FRAME);

    // parser state
    t_state            r_state,     n_state;
    logic [BYTE_W-1:0] r_frame_len, n_frame_len;
    logic [BYTE_W-1:0] r_byte_idx,  n_byte_idx;
    logic              r_frame_err, n_frame_err;
    logic [AW-1:0]     r_rd_idx,    n_rd_idx;
    logic [AW-1:0]     r_last_idx,  n_last_idx;

    // buffer and output register hookup
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [BYTE_W-1:0] rd_data;
    logic              out_free;
    logic              out_load;
    t_result           out_data;

    logic              rx_accept;
    logic [BYTE_W-1:0] rx_d;
    logic              len_bad;
    logic              at_end;

    rcfp_fwd_mem #(
        .DEPTH (MAX_FRAME),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_data)
    );

    rcfp_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load_en (out_load),
        .i_load    (out_data),
        .o_free    (out_free),
        .o_tx      (o_tx)
    );

    assign i_rx.ready = (r_state == ST_IDLE) && out_free;
    assign rx_accept  = i_rx.valid && i_rx.ready;
    assign rx_d       = i_rx.rx_byte;

    // length outside 4..MAX_FRAME marks the frame bad from the start
    assign len_bad = (rx_d < MIN_LEN) ||
                     ({1'b0, rx_d} > (BYTE_W+1)'(MAX_FRAME));
    // terminator slot reached (frame length is nonzero here)
    assign at_end  = r_byte_idx >= (r_frame_len - 8'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_frame_len <= '0;
            r_byte_idx  <= '0;
            r_frame_err <= 1'b0;
            r_rd_idx    <= '0;
            r_last_idx  <= '0;
        end else begin
            r_state     <= n_state;
            r_frame_len <= n_frame_len;
            r_byte_idx  <= n_byte_idx;
            r_frame_err <= n_frame_err;
            r_rd_idx    <= n_rd_idx;
            r_last_idx  <= n_last_idx;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_frame_len = r_frame_len;
        n_byte_idx  = r_byte_idx;
        n_frame_err = r_frame_err;
        n_rd_idx    = r_rd_idx;
        n_last_idx  = r_last_idx;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = rx_d;
        rd_en       = 1'b0;
        out_load    = 1'b0;
        out_data    = '{kind: KIND_TX, value: FRAME_END, last: 1'b1};

        unique case (r_state)
            ST_IDLE: begin
                if (rx_accept) begin
                    if (r_frame_len == '0) begin
                        // waiting for a length; drop a zero byte
                        if (rx_d != '0) begin
                            n_frame_len = rx_d;
                            n_byte_idx  = 8'd1;
                            n_frame_err = len_bad;
                            if (!len_bad) begin
                                wr_en   = 1'b1;
                                wr_addr = '0;
                                wr_data = rx_d - HEADER_SKIP;
                            end
                        end
                    end else if (at_end) begin
                        if (rx_d == FRAME_END) begin
                            if (!r_frame_err) begin
                                // shortest frame forwards only the terminator
                                if (r_frame_len == MIN_LEN) begin
                                    out_load = 1'b1;
                                end else begin
                                    n_state    = ST_READ;
                                    n_rd_idx   = '0;
                                    n_last_idx = AW'(r_frame_len - MIN_LEN);
                                end
                            end
                            n_frame_len = '0;
                            n_byte_idx  = '0;
                            n_frame_err = 1'b0;
                        end else begin
                            // hold the index; keep checking for the terminator
                            n_frame_err = 1'b1;
                        end
                    end else begin
                        unique case (r_byte_idx)
                            8'd1: begin
                                out_load = 1'b1;
                                out_data = '{kind: KIND_RED, value: rx_d, last: 1'b1};
                            end
                            8'd2: begin
                                out_load = 1'b1;
                                out_data = '{kind: KIND_GREEN, value: rx_d, last: 1'b1};
                            end
                            8'd3: begin
                                out_load = 1'b1;
                                out_data = '{kind: KIND_BLUE, value: rx_d, last: 1'b1};
                            end
                            default: begin
                                if (!r_frame_err) begin
                                    wr_en   = 1'b1;
                                    wr_addr = AW'(r_byte_idx - HEADER_SKIP);
                                end
                            end
                        endcase
                        n_byte_idx = r_byte_idx + 8'd1;
                    end
                end
            end

            ST_READ: begin
                if (r_rd_idx == r_last_idx) begin
                    // final byte is always the terminator
                    if (out_free) begin
                        out_load = 1'b1;
                        n_state  = ST_IDLE;
                    end
                end else begin
                    rd_en   = 1'b1;
                    n_state = ST_SEND;
                end
            end

            ST_SEND: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_data = '{kind: KIND_TX, value: rd_data, last: 1'b0};
                    n_rd_idx = r_rd_idx + AW'(1);
                    n_state  = ST_READ;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // no input is taken while a replay is in flight
    a_no_rx_in_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !i_rx.ready)
        else $error("input ready during replay");

    // a pending final forwarded byte means the replay has finished
    a_last_tx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tx.valid && (o_tx.kind == KIND_TX) && o_tx.last) |-> (r_state == ST_IDLE))
        else $error("final forwarded byte while replay still active");

    // the frame position stays inside the frame (a one-byte frame sits at 1)
    a_idx_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frame_len > 8'd1) |-> (r_byte_idx < r_frame_len))
        else $error("byte index beyond frame length");

    // idle parser has no position
    a_idx_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frame_len == '0) |-> (r_byte_idx == '0) && !r_frame_err)
        else $error("stale frame state while waiting for length");

endmodule

`default_nettype wire

// ===== dv/rgb_chain_frame_parser_core_test.sv =====
// ----------------------------------------------------------------------------
// rgb_chain_frame_parser_core_test
// Self-checking bench for the RGB chain frame parser. Serial bytes go in one
// transaction at a time. A local frame tracker predicts the duty updates and
// the forwarded frame bytes. Every output transaction is checked in order
// against that prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_chain_frame_parser_core_test;

    import rcfp_pkg::*;

    localparam int MAX_FRAME    = MAX_FRAME_DEF;
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
    localparam int SETTLE_CYCLES = 150;    // covers a full 61-byte replay
    localparam int RANDOM_ITEMS = 40;
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    logic i_clk;
    logic i_rst_n;

    rcfp_rx_if rx_chan();
    rcfp_tx_if tx_chan();

    rgb_chain_frame_parser_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_chan),
        .o_tx    (tx_chan)
    );

    // ------------------------------------------------------------------------
    // Frame tracker state: mirrors what the parser should hold.
    // ------------------------------------------------------------------------
    logic [7:0] frm_len;                 // 0 = waiting for a length byte
    logic [7:0] frm_pos;                 // position of the next byte
    logic       frm_bad;                 // frame will be dropped at 0x0d
    logic [7:0] fwd_buf [MAX_FRAME];     // rebuilt frame for the next node

    t_result duty_fwd_q [$];             // duty updates and forwarded bytes due
    int      errors;
    int      bytes_taken;                // bytes that the parser acts on
    bit      rx_gaps_on;                 // sender inserts idle cycles
    bit      hold_req;                   // ask the receiver for a long hold-off

    // ------------------------------------------------------------------------
    // Clock and time limit.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor: advance the frame tracker by one accepted byte and queue
    // whatever results that byte causes.
    // ------------------------------------------------------------------------
    task automatic parse_rx_byte(input logic [7:0] b);
        int      cnt;
        int      idx;
        t_result res;
        if (frm_len == 8'd0) begin
            // Waiting for a length; a zero byte is ignored.
            if (b != 8'd0) begin
                frm_len = b;
                frm_pos = 8'd1;
                if (b < MIN_LEN || b > MAX_FRAME) begin
                    frm_bad = 1'b1;
                end else begin
                    frm_bad    = 1'b0;
                    fwd_buf[0] = b - HEADER_SKIP;
                end
            end
        end else if (frm_pos >= frm_len - 1) begin
            // Terminator slot takes precedence over duty and payload.
            if (b == FRAME_END) begin
                if (!frm_bad) begin
                    cnt = frm_len - HEADER_SKIP;
                    if (cnt >= 1 && cnt <= MAX_FRAME) begin
                        fwd_buf[cnt-1] = FRAME_END;
                        for (int i = 0; i < cnt; i++) begin
                            res.kind  = KIND_TX;
                            res.value = fwd_buf[i];
                            res.last  = (i == cnt - 1);
                            duty_fwd_q.push_back(res);
                        end
                    end
                end
                frm_len = 8'd0;
                frm_pos = 8'd0;
                frm_bad = 1'b0;
            end else begin
                // Wrong final byte: hold position, recheck every later byte.
                frm_bad = 1'b1;
            end
        end else begin
            if (frm_pos >= 8'd1 && frm_pos <= 8'd3) begin
                case (frm_pos)
                    8'd1:    res.kind = KIND_RED;
                    8'd2:    res.kind = KIND_GREEN;
                    default: res.kind = KIND_BLUE;
                endcase
                res.value = b;
                res.last  = 1'b1;
                duty_fwd_q.push_back(res);
            end else if (frm_pos > HEADER_SKIP && !frm_bad) begin
                idx = frm_pos - HEADER_SKIP;
                if (idx < MAX_FRAME) begin
                    fwd_buf[idx] = b;
                end
            end
            frm_pos = frm_pos + 8'd1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender: offer one byte, hold it until the transaction completes, then
    // optionally idle. Valid stays high when no gap follows, so back-to-back
    // bytes never see valid lowered and raised in one step.
    // ------------------------------------------------------------------------
    task automatic push_rx_byte(input logic [7:0] b);
        int r;
        int gap;
        rx_chan.valid   <= 1'b1;
        rx_chan.rx_byte <= b;
        do @(posedge i_clk); while (!rx_chan.ready);
        if (!(frm_len == 8'd0 && b == 8'd0)) begin
            bytes_taken++;
        end
        parse_rx_byte(b);
        gap = 0;
        if (rx_gaps_on) begin
            r = $urandom_range(0, 99);
            if (r >= 95) begin
                gap = $urandom_range(10, 40);
            end else if (r >= 70) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            rx_chan.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Send a whole frame: length, body, then the final byte. A tail other
    // than 0x0d marks the frame bad; extra wrong bytes follow before the
    // terminator that finally drops it.
    task automatic push_frame(input int len, input logic [7:0] tail, input int extra);
        logic [7:0] b;
        push_rx_byte(len[7:0]);
        for (int p = 1; p <= len - 2; p++) begin
            push_rx_byte(8'($urandom_range(0, 255)));
        end
        if (tail != FRAME_END) begin
            push_rx_byte(tail);
            for (int k = 0; k < extra; k++) begin
                do b = 8'($urandom_range(0, 255)); while (b == FRAME_END);
                push_rx_byte(b);
            end
        end
        push_rx_byte(FRAME_END);
    endtask

    // Drop valid and hold until every predicted result has come out.
    task automatic wait_chain_idle();
        rx_chan.valid <= 1'b0;
        while (duty_fwd_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random ready with short stalls, rare long stalls and calm
    // stretches; a hold request forces one long hold-off.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int r;
        int stall_left;
        int calm_left;
        stall_left    = 0;
        calm_left     = 0;
        tx_chan.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
                calm_left  = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                tx_chan.ready <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                tx_chan.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    tx_chan.ready <= 1'b1;
                end else if (r < 85) begin
                    stall_left = $urandom_range(0, 2);
                    tx_chan.ready <= 1'b0;
                end else if (r < 95) begin
                    calm_left = $urandom_range(20, 120);
                    tx_chan.ready <= 1'b1;
                end else begin
                    stall_left = $urandom_range(10, 50);
                    tx_chan.ready <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker: compare each output transaction with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && tx_chan.valid && tx_chan.ready) begin
            if (duty_fwd_q.size() == 0) begin
                $display("%0t: unexpected result kind %0d value 0x%02h last %0b",
                         $time, tx_chan.kind, tx_chan.value, tx_chan.last);
                errors++;
            end else begin
                want = duty_fwd_q.pop_front();
                if (tx_chan.kind !== want.kind) begin
                    $display("%0t: kind mismatch: expected %0d, actual %0d",
                             $time, want.kind, tx_chan.kind);
                    errors++;
                end
                if (tx_chan.value !== want.value) begin
                    $display("%0t: value mismatch: expected 0x%02h, actual 0x%02h",
                             $time, want.value, tx_chan.value);
                    errors++;
                end
                if (tx_chan.last !== want.last) begin
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, want.last, tx_chan.last);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Field extremes and special cases, one short frame each.
    task automatic test_directed();
        rx_gaps_on = 1'b1;
        push_rx_byte(8'h00);                        // zero length: ignored
        // Length four: terminator sits in the blue slot, replay is 0x0d only.
        push_rx_byte(8'h04);
        push_rx_byte(8'hff);
        push_rx_byte(8'h00);
        push_rx_byte(FRAME_END);
        // Good frame with 0x0d inside the payload.
        push_rx_byte(8'h06);
        push_rx_byte(8'h00);
        push_rx_byte(8'hff);
        push_rx_byte(8'h80);
        push_rx_byte(FRAME_END);
        push_rx_byte(FRAME_END);
        // Short bad lengths: frame dropped; only length three gives a duty update.
        push_rx_byte(8'h03);
        push_rx_byte(8'h55);
        push_rx_byte(FRAME_END);
        push_rx_byte(8'h01);
        push_rx_byte(FRAME_END);
        push_rx_byte(8'h02);
        push_rx_byte(FRAME_END);
        // Wrong final byte, another wrong byte, then the dropping 0x0d.
        push_rx_byte(8'h05);
        push_rx_byte(8'h11);
        push_rx_byte(8'h22);
        push_rx_byte(8'h33);
        push_rx_byte(8'haa);
        push_rx_byte(8'hff);
        push_rx_byte(FRAME_END);
        wait_chain_idle();
    endtask

    // Largest frame while the receiver holds off: the output register fills
    // and the input must stall; the full 61-byte replay follows.
    task automatic test_long_hold();
        rx_gaps_on = 1'b0;
        hold_req   = 1'b1;
        push_frame(MAX_FRAME, FRAME_END, 0);
        wait_chain_idle();
        rx_gaps_on = 1'b1;
    endtask

    // Length over capacity: counted through, duty given, never replayed,
    // with wrong final bytes before the dropping terminator.
    task automatic test_oversize();
        rx_gaps_on = 1'b0;
        push_frame(MAX_FRAME + 1, 8'ha5, 2);
        wait_chain_idle();
    endtask

    // Mostly well-formed frames with random content, mixed with noise.
    task automatic test_random();
        int start;
        int r;
        int len;
        logic [7:0] tail;
        start = bytes_taken;
        while (bytes_taken - start < RANDOM_ITEMS) begin
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 8) begin
                repeat ($urandom_range(1, 3)) push_rx_byte(8'h00);
            end else if (r < 16) begin
                do tail = 8'($urandom_range(0, 255)); while (tail == FRAME_END);
                if ($urandom_range(0, 1)) tail = FRAME_END;
                push_frame($urandom_range(1, 3), tail, $urandom_range(0, 2));
            end else if (r < 26) begin
                do tail = 8'($urandom_range(0, 255)); while (tail == FRAME_END);
                push_frame($urandom_range(4, 12), tail, $urandom_range(0, 3));
            end else if (r < 32) begin
                len = $urandom_range(20, MAX_FRAME);
                push_frame(len, FRAME_END, 0);
            end else begin
                push_frame($urandom_range(4, 12), FRAME_END, 0);
            end
        end
        wait_chain_idle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        errors      = 0;
        bytes_taken = 0;
        rx_gaps_on  = 1'b0;
        hold_req    = 1'b0;
        frm_len     = 8'd0;
        frm_pos     = 8'd0;
        frm_bad     = 1'b0;

        i_rst_n         <= 1'b0;
        rx_chan.valid   <= 1'b0;
        rx_chan.rx_byte <= 8'h00;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_long_hold();
        test_oversize();
        test_random();

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
